[sv/bcc_pkg.sv]
// shared constants and types of the box collision contact block
package bcc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NORM_W    = 18;
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int QW        = FRAC_BITS + 1;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic [NORM_W-1:0] NORM_ONE     = NORM_W'(64'd1 << FRAC_BITS);
    localparam logic [NORM_W-1:0] NORM_ONE_NEG = NORM_W'(64'd0 - (64'd1 << FRAC_BITS));

    // one queued word between classification and the distance pipeline
    typedef struct packed {
        logic              live;    // circle pair still needs distance work
        logic              hit;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [30:0]       depth;
        logic [31:0]       px;
        logic [31:0]       py;
        logic              sx;
        logic              sy;
        logic [30:0]       mx;
        logic [30:0]       my;
        logic [30:0]       rad;
    } t_job;

endpackage

[sv/bcc_if.sv]
// valid/ready channels of the box collision contact block
interface bcc_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] box_center_x;
    logic signed [31:0] box_center_y;
    logic [30:0]        box_half_x;
    logic [30:0]        box_half_y;
    logic signed [31:0] other_center_x;
    logic signed [31:0] other_center_y;
    logic [30:0]        other_half_x;
    logic [30:0]        other_half_y;
    logic [30:0]        other_radius;

    modport source (
        output valid, action, box_center_x, box_center_y, box_half_x, box_half_y,
               other_center_x, other_center_y, other_half_x, other_half_y, other_radius,
        input  ready
    );
    modport sink (
        input  valid, action, box_center_x, box_center_y, box_half_x, box_half_y,
               other_center_x, other_center_y, other_half_x, other_half_y, other_radius,
        output ready
    );
endinterface

interface bcc_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [17:0] normal_x;
    logic signed [17:0] normal_y;
    logic [30:0]        depth;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;

    modport source (
        output valid, hit, normal_x, normal_y, depth, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, hit, normal_x, normal_y, depth, point_x, point_y,
        output ready
    );
endinterface

[sv/bcc_front.sv]
// front end: input register, bounds, box test and circle clamp
module bcc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bcc_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output bcc_pkg::t_job o_job
);
    import bcc_pkg::*;

    typedef struct packed {
        logic               circ;
        logic signed [31:0] bcx;
        logic signed [31:0] bcy;
        logic signed [31:0] ocx;
        logic signed [31:0] ocy;
        logic signed [33:0] bminx;
        logic signed [33:0] bmaxx;
        logic signed [33:0] bminy;
        logic signed [33:0] bmaxy;
        logic signed [33:0] ominx;
        logic signed [33:0] omaxx;
        logic signed [33:0] ominy;
        logic signed [33:0] omaxy;
        logic [30:0]        rad;
    } t_s1;

    logic r_s1_valid;
    t_s1  r_s1;
    t_s1  n_s1;

    logic               hit_b, xsel;
    logic signed [33:0] lox, hix, loy, hiy;
    logic signed [34:0] ovx, ovy, dep;
    logic [30:0]        dsat;
    logic signed [32:0] sumx, sumy;
    logic signed [33:0] ocx34, ocy34, clx, cly;
    logic signed [34:0] dx, dy;
    logic               far;
    logic [34:0]        adx, ady;

    assign i_in.ready = !r_s1_valid || !i_full;
    assign o_push     = r_s1_valid && !i_full;

    // bounds at full width so they never wrap
    always_comb begin
        n_s1.circ  = i_in.action;
        n_s1.bcx   = i_in.box_center_x;
        n_s1.bcy   = i_in.box_center_y;
        n_s1.ocx   = i_in.other_center_x;
        n_s1.ocy   = i_in.other_center_y;
        n_s1.bminx = 34'(i_in.box_center_x) - $signed({3'b0, i_in.box_half_x});
        n_s1.bmaxx = 34'(i_in.box_center_x) + $signed({3'b0, i_in.box_half_x});
        n_s1.bminy = 34'(i_in.box_center_y) - $signed({3'b0, i_in.box_half_y});
        n_s1.bmaxy = 34'(i_in.box_center_y) + $signed({3'b0, i_in.box_half_y});
        n_s1.ominx = 34'(i_in.other_center_x) - $signed({3'b0, i_in.other_half_x});
        n_s1.omaxx = 34'(i_in.other_center_x) + $signed({3'b0, i_in.other_half_x});
        n_s1.ominy = 34'(i_in.other_center_y) - $signed({3'b0, i_in.other_half_y});
        n_s1.omaxy = 34'(i_in.other_center_y) + $signed({3'b0, i_in.other_half_y});
        n_s1.rad   = i_in.other_radius;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_s1 <= n_s1;
        end
    end

    always_comb begin
        hit_b = !(r_s1.bmaxx < r_s1.ominx || r_s1.bminx > r_s1.omaxx ||
                  r_s1.bmaxy < r_s1.ominy || r_s1.bminy > r_s1.omaxy);
        lox   = (r_s1.bmaxx < r_s1.omaxx) ? r_s1.bmaxx : r_s1.omaxx;
        hix   = (r_s1.bminx > r_s1.ominx) ? r_s1.bminx : r_s1.ominx;
        loy   = (r_s1.bmaxy < r_s1.omaxy) ? r_s1.bmaxy : r_s1.omaxy;
        hiy   = (r_s1.bminy > r_s1.ominy) ? r_s1.bminy : r_s1.ominy;
        ovx   = 35'(lox) - 35'(hix);
        ovy   = 35'(loy) - 35'(hiy);
        xsel  = ovx < ovy;
        dep   = xsel ? ovx : ovy;
        dsat  = (dep > 35'sh7FFFFFFF) ? 31'h7FFFFFFF : dep[30:0];
        sumx  = 33'(r_s1.bcx) + 33'(r_s1.ocx);
        sumy  = 33'(r_s1.bcy) + 33'(r_s1.ocy);

        // clamp the circle center into the box
        ocx34 = 34'(r_s1.ocx);
        ocy34 = 34'(r_s1.ocy);
        clx   = (ocx34 < r_s1.bminx) ? r_s1.bminx :
                ((ocx34 > r_s1.bmaxx) ? r_s1.bmaxx : ocx34);
        cly   = (ocy34 < r_s1.bminy) ? r_s1.bminy :
                ((ocy34 > r_s1.bmaxy) ? r_s1.bmaxy : ocy34);
        dx    = 35'(r_s1.ocx) - 35'(clx);
        dy    = 35'(r_s1.ocy) - 35'(cly);
        adx   = dx[34] ? 35'(-dx) : 35'(dx);
        ady   = dy[34] ? 35'(-dy) : 35'(dy);
        far   = (adx >= 35'h80000000) || (ady >= 35'h80000000);

        o_job = '0;
        if (!r_s1.circ) begin
            o_job.hit = hit_b;
            if (hit_b) begin
                o_job.depth = dsat;
                o_job.px    = sumx[32:1];
                o_job.py    = sumy[32:1];
                if (xsel) begin
                    o_job.nx = (r_s1.bcx < r_s1.ocx) ? NORM_ONE_NEG : NORM_ONE;
                end else begin
                    o_job.ny = (r_s1.bcy > r_s1.ocy) ? NORM_ONE : NORM_ONE_NEG;
                end
            end
        end else begin
            o_job.live = !far;
            o_job.px   = clx[31:0];
            o_job.py   = cly[31:0];
            o_job.sx   = dx[34];
            o_job.sy   = dy[34];
            o_job.mx   = adx[30:0];
            o_job.my   = ady[30:0];
            o_job.rad  = r_s1.rad;
        end
    end

endmodule

[sv/bcc_queue.sv]
// short word queue between the front end and the distance pipeline
module bcc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bcc_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output bcc_pkg::t_job o_job
);
    import bcc_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[sv/bcc_back.sv]
// back end: squares, square root and normal division pipeline, output register
module bcc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  bcc_pkg::t_job i_job,
    output logic          o_pop,
    bcc_out_if.source     o_out
);
    import bcc_pkg::*;

    localparam int SQ0  = 2;
    localparam int DV0  = SQ0 + SQ_STEPS;
    localparam int NSTG = DV0 + DIV_STEPS;

    typedef struct packed {
        logic              live;
        logic              hit;
        logic              zero;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [30:0]       depth;
        logic [31:0]       px;
        logic [31:0]       py;
        logic              sx;
        logic              sy;
        logic [30:0]       mx;
        logic [30:0]       my;
        logic [30:0]       rad;
        logic [61:0]       sqx;
        logic [61:0]       sqy;
        logic [61:0]       sqr;
        logic [61:0]       n;
        logic [31:0]       rem;
        logic [30:0]       root;
        logic [31:0]       rx;
        logic [31:0]       ry;
        logic [QW-1:0]     qx;
        logic [QW-1:0]     qy;
    } t_bk;

    t_bk  r_p [NSTG];
    t_bk  n_p [NSTG];
    logic r_v [NSTG];
    logic adv;

    logic               r_out_valid;
    logic               r_hit;
    logic [NORM_W-1:0]  r_nx, r_ny;
    logic [30:0]        r_depth;
    logic [31:0]        r_px, r_py;
    logic [NORM_W-1:0]  n_nx, n_ny;
    logic [30:0]        n_depth;
    logic [31:0]        n_px, n_py;
    logic [63:0]        qxe, qye;

    assign adv   = !r_out_valid || o_out.ready;
    assign o_pop = adv && !i_empty;

    // squares
    always_comb begin
        n_p[0]       = '0;
        n_p[0].live  = i_job.live;
        n_p[0].hit   = i_job.hit;
        n_p[0].nx    = i_job.nx;
        n_p[0].ny    = i_job.ny;
        n_p[0].depth = i_job.depth;
        n_p[0].px    = i_job.px;
        n_p[0].py    = i_job.py;
        n_p[0].sx    = i_job.sx;
        n_p[0].sy    = i_job.sy;
        n_p[0].mx    = i_job.mx;
        n_p[0].my    = i_job.my;
        n_p[0].rad   = i_job.rad;
        n_p[0].sqx   = 62'(i_job.mx) * 62'(i_job.mx);
        n_p[0].sqy   = 62'(i_job.my) * 62'(i_job.my);
        n_p[0].sqr   = 62'(i_job.rad) * 62'(i_job.rad);
    end

    // squared distance, hit test against squared radius
    always_comb begin
        logic [62:0] dsq;
        dsq    = 63'(r_p[0].sqx) + 63'(r_p[0].sqy);
        n_p[1] = r_p[0];
        if (r_p[0].live) begin
            n_p[1].hit = dsq <= 63'(r_p[0].sqr);
        end
        n_p[1].zero = dsq == '0;
        n_p[1].n    = dsq[61:0];
        n_p[1].rem  = '0;
        n_p[1].root = '0;
        n_p[1].rx   = 32'(r_p[0].mx);
        n_p[1].ry   = 32'(r_p[0].my);
        n_p[1].qx   = '0;
        n_p[1].qy   = '0;
    end

    // one root bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        always_comb begin
            logic [33:0] r4, trial;
            r4    = {r_p[SQ0+k-1].rem, r_p[SQ0+k-1].n[61-2*k -: 2]};
            trial = {1'b0, r_p[SQ0+k-1].root, 2'b01};
            n_p[SQ0+k] = r_p[SQ0+k-1];
            if (r4 >= trial) begin
                n_p[SQ0+k].rem  = 32'(r4 - trial);
                n_p[SQ0+k].root = {r_p[SQ0+k-1].root[29:0], 1'b1};
            end else begin
                n_p[SQ0+k].rem  = r4[31:0];
                n_p[SQ0+k].root = {r_p[SQ0+k-1].root[29:0], 1'b0};
            end
        end
    end

    // one quotient bit per stage for both normal components
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        always_comb begin
            logic [31:0] dlen, rx, ry;
            dlen = 32'(r_p[DV0+j-1].root);
            rx   = r_p[DV0+j-1].rx;
            ry   = r_p[DV0+j-1].ry;
            n_p[DV0+j] = r_p[DV0+j-1];
            if (rx >= dlen) begin
                n_p[DV0+j].qx[FRAC_BITS-j] = 1'b1;
                rx = rx - dlen;
            end
            if (ry >= dlen) begin
                n_p[DV0+j].qy[FRAC_BITS-j] = 1'b1;
                ry = ry - dlen;
            end
            if (j < FRAC_BITS) begin
                rx = {rx[30:0], 1'b0};
                ry = {ry[30:0], 1'b0};
            end
            n_p[DV0+j].rx = rx;
            n_p[DV0+j].ry = ry;
        end
    end

    // result assembly from the last stage
    always_comb begin
        qxe     = 64'(r_p[NSTG-1].qx);
        qye     = 64'(r_p[NSTG-1].qy);
        n_nx    = '0;
        n_ny    = '0;
        n_depth = '0;
        n_px    = '0;
        n_py    = '0;
        if (r_p[NSTG-1].hit) begin
            n_px = r_p[NSTG-1].px;
            n_py = r_p[NSTG-1].py;
            if (!r_p[NSTG-1].live) begin
                n_nx    = r_p[NSTG-1].nx;
                n_ny    = r_p[NSTG-1].ny;
                n_depth = r_p[NSTG-1].depth;
            end else if (r_p[NSTG-1].zero) begin
                n_ny    = NORM_ONE;
                n_depth = r_p[NSTG-1].rad;
            end else begin
                n_nx    = r_p[NSTG-1].sx ? NORM_W'(64'd0 - qxe) : NORM_W'(qxe);
                n_ny    = r_p[NSTG-1].sy ? NORM_W'(64'd0 - qye) : NORM_W'(qye);
                n_depth = r_p[NSTG-1].rad - r_p[NSTG-1].root;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) begin
                r_v[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v[0] <= o_pop;
            for (int s = 1; s < NSTG; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_out_valid <= r_v[NSTG-1];
        end
        if (adv) begin
            for (int s = 0; s < NSTG; s++) begin
                r_p[s] <= n_p[s];
            end
            r_hit   <= r_p[NSTG-1].hit;
            r_nx    <= n_nx;
            r_ny    <= n_ny;
            r_depth <= n_depth;
            r_px    <= n_px;
            r_py    <= n_py;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.hit      = r_hit;
    assign o_out.normal_x = r_nx;
    assign o_out.normal_y = r_ny;
    assign o_out.depth    = r_depth;
    assign o_out.point_x  = r_px;
    assign o_out.point_y  = r_py;

endmodule

[sv/box_collision_contact.sv]
// top level of the box collision contact block
//
// narrow-phase test of one box against a second box or a circle, Q16.16
// channels: i_in takes one shape pair per word (action 0 box, 1 circle),
//   o_out gives one contact word per pair, in order: hit, normal, depth, point
// both channels are valid/ready; a word moves when valid and ready are high
// throughput: one pair per cycle sustained while o_out.ready stays high
// path from acceptance to o_out.valid: input register, queue, squares and
//   squared distance stages, the square root (31 stages, one root bit each),
//   the normal division (FRAC_BITS + 1 stages, one quotient bit each), output register
// front end registers the pair, works out bounds, the box result and the
//   circle clamp, and writes a word into a four-entry queue
// back end drains the queue through squares, root and division stages
//   into the output register
// receiver stall: the whole back pipeline holds; the queue then fills and
//   the front end drops i_in.ready once the queue and its register are full
// reset: synchronous, active low; drops all words in flight, no clearing pass
module box_collision_contact (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bcc_in_if.sink    i_in,
    bcc_out_if.source o_out
);
    import bcc_pkg::*;

    logic push, pop, full, empty;
    t_job job_in, job_out;

    // classification and box arithmetic
    bcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    // decouples the two halves
    bcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_job   (job_out)
    );

    // circle distance, normal and output register
    bcc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[tb/sv/tb.sv]
// testbench of the box collision contact block: directed and random shape pairs
module tb;
    import bcc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    bcc_in_if  in_ch();
    bcc_out_if out_ch();

    box_collision_contact DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    localparam int LATENCY = FRAC_BITS + 36;
    localparam int LIMIT   = 400000;

    typedef struct packed {
        logic        circle;
        logic [31:0] bcx;
        logic [31:0] bcy;
        logic [30:0] bhx;
        logic [30:0] bhy;
        logic [31:0] ocx;
        logic [31:0] ocy;
        logic [30:0] ohx;
        logic [30:0] ohy;
        logic [30:0] rad;
    } t_pair;

    typedef struct packed {
        logic        hit;
        logic [17:0] nx;
        logic [17:0] ny;
        logic [30:0] depth;
        logic [31:0] px;
        logic [31:0] py;
    } t_contact;

    t_contact contact_q[$];
    int       errors;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_recv;
    int       hold_cycles;
    longint   cycle_cnt;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(longint d, longint dlen);
        longint unsigned m;
        longint unsigned q;
        m = d < 0 ? -d : d;
        q = (m << FRAC_BITS) / dlen;
        if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_contact predict_contact(t_pair p);
        longint one, bcx, bcy, bhx, bhy, ocx, ocy, ohx, ohy, rad;
        longint bminx, bmaxx, bminy, bmaxy, ominx, omaxx, ominy, omaxy;
        longint ovx, ovy, clx, cly, dx, dy, dlen;
        longint nx, ny, dep, px, py;
        longint unsigned dsq, rsq;
        bit hit;
        t_contact c;
        one = longint'(1) << FRAC_BITS;
        bcx = longint'($signed(p.bcx)); bcy = longint'($signed(p.bcy));
        ocx = longint'($signed(p.ocx)); ocy = longint'($signed(p.ocy));
        bhx = p.bhx; bhy = p.bhy; ohx = p.ohx; ohy = p.ohy; rad = p.rad;
        bminx = bcx - bhx; bmaxx = bcx + bhx;
        bminy = bcy - bhy; bmaxy = bcy + bhy;
        nx = 0; ny = 0; dep = 0; px = 0; py = 0;
        if (!p.circle) begin
            ominx = ocx - ohx; omaxx = ocx + ohx;
            ominy = ocy - ohy; omaxy = ocy + ohy;
            hit = !(bmaxx < ominx || bminx > omaxx || bmaxy < ominy || bminy > omaxy);
            if (hit) begin
                ovx = (bmaxx < omaxx ? bmaxx : omaxx) - (bminx > ominx ? bminx : ominx);
                ovy = (bmaxy < omaxy ? bmaxy : omaxy) - (bminy > ominy ? bminy : ominy);
                px = (bcx + ocx) >>> 1;
                py = (bcy + ocy) >>> 1;
                if (ovx < ovy) begin
                    nx = bcx < ocx ? -one : one;
                    dep = ovx;
                end else begin
                    ny = bcy > ocy ? one : -one;
                    dep = ovy;
                end
                if (dep > 64'h7FFFFFFF) dep = 64'h7FFFFFFF;
            end
        end else begin
            clx = ocx < bminx ? bminx : (ocx > bmaxx ? bmaxx : ocx);
            cly = ocy < bminy ? bminy : (ocy > bmaxy ? bmaxy : ocy);
            dx = ocx - clx; dy = ocy - cly;
            if (dx >= 64'sh80000000 || dx <= -64'sh80000000 ||
                dy >= 64'sh80000000 || dy <= -64'sh80000000) begin
                hit = 0;
            end else begin
                dsq = dx * dx + dy * dy;
                rsq = rad * rad;
                hit = dsq <= rsq;
                if (hit) begin
                    px = clx; py = cly;
                    if (dsq == 0) begin
                        ny = one;
                        dep = rad;
                    end else begin
                        dlen = root_floor(dsq);
                        nx = unit_part(dx, dlen);
                        ny = unit_part(dy, dlen);
                        dep = rad - dlen;
                    end
                end
            end
        end
        c.hit = hit; c.nx = nx[17:0]; c.ny = ny[17:0];
        c.depth = dep[30:0]; c.px = px[31:0]; c.py = py[31:0];
        return c;
    endfunction

    // offer one pair, hold until accepted, then record its contact
    task automatic send_pair(t_pair p);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.action         <= p.circle;
        in_ch.box_center_x   <= p.bcx;
        in_ch.box_center_y   <= p.bcy;
        in_ch.box_half_x     <= p.bhx;
        in_ch.box_half_y     <= p.bhy;
        in_ch.other_center_x <= p.ocx;
        in_ch.other_center_y <= p.ocy;
        in_ch.other_half_x   <= p.ohx;
        in_ch.other_half_y   <= p.ohy;
        in_ch.other_radius   <= p.rad;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        contact_q.push_back(predict_contact(p));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (contact_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) << 12;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3)
                                              : 32'h80000000 + $urandom_range(3);
        endcase
    endfunction

    function automatic logic [30:0] rnd_half();
        case ($urandom_range(3))
            0: return 31'($urandom);
            1: return 31'($urandom_range(600)) << 12;
            2: return 31'($urandom_range(65536));
            default: return $urandom_range(1) ? 31'h7FFFFFFF : 31'd0;
        endcase
    endfunction

    // mostly nearby pairs so that hits are common, with full-range noise
    function automatic t_pair rnd_pair();
        t_pair p;
        p.circle = 1'($urandom_range(1));
        p.bcx = rnd_coord(); p.bcy = rnd_coord();
        p.bhx = rnd_half();  p.bhy = rnd_half();
        p.ohx = rnd_half();  p.ohy = rnd_half(); p.rad = rnd_half();
        if ($urandom_range(99) < 75) begin
            p.ocx = p.bcx + 32'($signed($urandom_range(8000)) - 4000) * 32'($urandom_range(4096));
            p.ocy = p.bcy + 32'($signed($urandom_range(8000)) - 4000) * 32'($urandom_range(4096));
        end else begin
            p.ocx = rnd_coord(); p.ocy = rnd_coord();
        end
        return p;
    endfunction

    function automatic t_pair mk(longint c, longint bx, longint by, longint hx,
                                 longint hy, longint ox, longint oy,
                                 longint qx, longint qy, longint r);
        t_pair p;
        p.circle = c[0];
        p.bcx    = bx[31:0];
        p.bcy    = by[31:0];
        p.bhx    = hx[30:0];
        p.bhy    = hy[30:0];
        p.ocx    = ox[31:0];
        p.ocy    = oy[31:0];
        p.ohx    = qx[30:0];
        p.ohy    = qy[30:0];
        p.rad    = r[30:0];
        return p;
    endfunction

    task automatic test_directed();
        localparam logic [31:0] U = 32'h10000;
        // touching boxes on x, apart boxes, equal overlaps (y axis wins)
        send_pair(mk(0, 0, 0, U, U, 2*U, 0, U, U, 0));
        send_pair(mk(0, 0, 0, U, U, 3*U, 0, U, U, 0));
        send_pair(mk(0, 0, 0, U, U, U, U, U, U, 0));
        send_pair(mk(0, 2*U, 0, U, 4*U, 0, 0, U, 4*U, 0));
        send_pair(mk(0, 0, 5*U, 4*U, U, 0, 4*U, 4*U, U, 0));
        send_pair(mk(0, 0, 0, 4*U, U, 0, U, 4*U, U, 0));
        // odd negative midpoint, extremes of centers and halves
        send_pair(mk(0, 32'hFFFFFFFF, 32'hFFFFFFFD, 5, 5, 0, 0, 5, 5, 0));
        send_pair(mk(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                     32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF, 0));
        send_pair(mk(0, 32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 31'h7FFFFFFF));
        // circle inside (zero distance), touching, just missing, diagonal
        send_pair(mk(1, 0, 0, U, U, 0, 0, 0, 0, 3*U));
        send_pair(mk(1, 0, 0, U, U, 2*U, 0, 0, 0, U));
        send_pair(mk(1, 0, 0, U, U, 2*U + 1, 0, 0, 0, U));
        send_pair(mk(1, 0, 0, U, U, 3*U, 3*U, 0, 0, 4*U));
        send_pair(mk(1, 0, 0, U, U, -3*U, -2*U, 31'h7FFFFFFF, 31'h7FFFFFFF, 5*U));
        send_pair(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // far circle and huge radius
        send_pair(mk(1, 32'h80000000, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 31'h7FFFFFFF));
        send_pair(mk(1, 32'h80000000, 32'h80000000, 0, 0, 32'h80000000 + 32'h7FFFFFFF,
                     32'h80000000, 0, 0, 31'h7FFFFFFF));
        send_pair(mk(1, 0, 0, 0, 0, 32'h30000000, 32'hD0000000, 0, 0, 31'h7FFFFFFF));
        send_pair(mk(1, 0, 0, 0, 0, 1, 1, 0, 0, 2));
        wait_drained();
    endtask

    task automatic test_random(int n);
        repeat (n) send_pair(rnd_pair());
    endtask

    // receiver holds off long enough for the queue to fill and stall i_in
    task automatic test_backpressure();
        hold_cycles = 200;
        hold_recv   = 1'b1;
        test_random(150);
        wait_drained();
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_recv = 0;
        hold_cycles = 0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.action <= 1'b0;
        in_ch.box_center_x <= '0;
        in_ch.box_center_y <= '0;
        in_ch.box_half_x <= '0;
        in_ch.box_half_y <= '0;
        in_ch.other_center_x <= '0;
        in_ch.other_center_y <= '0;
        in_ch.other_half_x <= '0;
        in_ch.other_half_y <= '0;
        in_ch.other_radius <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 17; recv_idle_pct = 68;
        test_random(600);
        wait_drained();
        send_idle_pct = 68; recv_idle_pct = 17;
        test_random(550);
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(530);
        test_backpressure();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // receiver ready, with random idling and the long hold-off
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_recv) begin
                out_ch.ready <= 1'b0;
                if (hold_cycles > 0) hold_cycles--;
                else hold_recv = 1'b0;
            end else begin
                out_ch.ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // compare each accepted contact word with the oldest prediction
    always @(posedge i_clk) begin
        t_contact e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (contact_q.size() == 0) begin
                errors++;
                $display("%0t unexpected word hit=%b", $time, out_ch.hit);
            end else begin
                e = contact_q.pop_front();
                if (e.hit !== out_ch.hit) begin
                    errors++;
                    $display("%0t hit exp %b got %b", $time, e.hit, out_ch.hit);
                end
                if (e.nx !== out_ch.normal_x) begin
                    errors++;
                    $display("%0t normal_x exp %h got %h", $time, e.nx, out_ch.normal_x);
                end
                if (e.ny !== out_ch.normal_y) begin
                    errors++;
                    $display("%0t normal_y exp %h got %h", $time, e.ny, out_ch.normal_y);
                end
                if (e.depth !== out_ch.depth) begin
                    errors++;
                    $display("%0t depth exp %h got %h", $time, e.depth, out_ch.depth);
                end
                if (e.px !== out_ch.point_x) begin
                    errors++;
                    $display("%0t point_x exp %h got %h", $time, e.px, out_ch.point_x);
                end
                if (e.py !== out_ch.point_y) begin
                    errors++;
                    $display("%0t point_y exp %h got %h", $time, e.py, out_ch.point_y);
                end
            end
        end
    end

    // watchdog
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end
endmodule
